// ===== hdl/lrrc_pkg.sv =====
`timescale 1ns / 1ps
package lrrc_pkg;

  localparam int REQ_W   = 2;
  localparam int RANKI_W = 4;
  localparam int COLI_W  = 8;
  localparam int VAL_W   = 16;
  localparam int SCL_W   = 32;
  localparam int PROD_W  = 48;
  localparam int RD_W    = 48;
  localparam int RND_W   = 29;
  localparam int SQ_W    = 56;
  localparam int TOT_W   = 64;
  localparam int WSQ_W   = 31;
  localparam int RATIO_W = 32;
  localparam int RNKR_W  = 5;
  localparam int COLR_W  = 9;
  localparam int CFGD_W  = 9;
  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 3;
  localparam int DIV_CNT_W  = 7;

  typedef enum logic [1:0] {
    REQ_WEIGHT = 2'd0,
    REQ_RIGHT  = 2'd1,
    REQ_LEFT   = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic {
    CFG_RANK = 1'b0,
    CFG_COLS = 1'b1
  } cfg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RLOAD,
    S_PASS,
    S_DEN,
    S_DIV,
    S_OUT
  } state_e;

endpackage

// ===== hdl/lrrc_cell.sv =====
`timescale 1ns / 1ps
module lrrc_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           shift_i,
  input  logic signed [lrrc_pkg::RD_W-1:0] data_i,
  output logic signed [lrrc_pkg::RD_W-1:0] data_o
);
  import lrrc_pkg::*;

  logic signed [RD_W-1:0] acc_q, acc_d;

  // One column of the row difference; the ring rotates by one on each shift.
  always_comb begin
    acc_d = shift_i ? data_i : acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign data_o = acc_q;

endmodule

// ===== hdl/lrrc_fact_mem.sv =====
`timescale 1ns / 1ps
module lrrc_fact_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [AW-1:0]                    waddr_i,
  input  logic signed [lrrc_pkg::SCL_W-1:0] wold_i,
  input  logic signed [lrrc_pkg::SCL_W-1:0] wnew_i,
  input  logic [AW-1:0]                    raddr_i,
  output logic signed [lrrc_pkg::SCL_W-1:0] rold_o,
  output logic signed [lrrc_pkg::SCL_W-1:0] rnew_o
);
  import lrrc_pkg::*;

  logic signed [SCL_W-1:0] old_mem [DEPTH];
  logic signed [SCL_W-1:0] new_mem [DEPTH];
  logic signed [SCL_W-1:0] rold_q, rnew_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      old_mem[waddr_i] <= wold_i;
      new_mem[waddr_i] <= wnew_i;
    end
    rold_q <= old_mem[raddr_i];
    rnew_q <= new_mem[raddr_i];
  end

  assign rold_o = rold_q;
  assign rnew_o = rnew_q;

endmodule

// ===== hdl/lrrc_div.sv =====
`timescale 1ns / 1ps
module lrrc_div #(
  parameter int DW = 36
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [lrrc_pkg::TOT_W-1:0]   dvd_i,
  input  logic [DW-1:0]                den_i,
  output logic                         done_o,
  output logic [lrrc_pkg::TOT_W-1:0]   quo_o
);
  import lrrc_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DW-1:0]        rem_q, rem_d;
  logic [DW-1:0]        den_q, den_d;
  logic [TOT_W-1:0]     quo_q, quo_d;
  logic [DW:0]          trial;
  logic [DW:0]          diff;
  logic                 fits;

  // Restoring division, one quotient bit per cycle, most significant first.
  always_comb begin
    trial  = {rem_q, quo_q[TOT_W-1]};
    diff   = trial - {1'b0, den_q};
    fits   = trial >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      den_d  = den_i;
      quo_d  = dvd_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[DW-1:0] : trial[DW-1:0];
      quo_d = {quo_q[TOT_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(TOT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== hdl/low_rank_relative_change.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Carries
// s_axis    in         tdata: rank_index, column_index, old_value, new_value
//                      tuser: req_type, final_item; tlast: row_end
// m_axis    out        tdata: ratio; tuser: zero_denominator
// cfg       in         write enable, register index, data
//
// Weight and right-factor pairs need no pass over the row. A left-factor pair
// that updates the row or ends it takes a full pass: the row store is a ring of
// MAX_COLUMNS cells rotated by one per column read from the factor memory.
// A final item then sums the squared old weights into the denominator, runs the
// serial divider and loads the output register. Reset clears the row, the total
// and the control state.
// A stalled result stays in the output register while new items are taken.
module low_rank_relative_change #(
  parameter int MAX_RANK    = 16,
  parameter int MAX_COLUMNS = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // rank_index, column_index, old_value, new_value, zero fill (from bit 0)
  input  logic [lrrc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // req_type, final_item (from bit 0)
  input  logic [lrrc_pkg::IN_USER_W-1:0]     s_axis_tuser,
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // ratio
  output logic [lrrc_pkg::RATIO_W-1:0]       m_axis_tdata,
  // zero_denominator
  output logic                               m_axis_tuser,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [lrrc_pkg::CFGD_W-1:0]        cfg_data_i
);
  import lrrc_pkg::*;

  localparam int RA    = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int RCW   = $clog2(MAX_RANK + 1);
  localparam int CNW   = $clog2(MAX_COLUMNS + 1);
  localparam int DEPTH = MAX_RANK * MAX_COLUMNS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DEN_W = WSQ_W + RCW;

  // Input fields
  logic [REQ_W-1:0]        in_req;
  logic [RANKI_W-1:0]      in_k;
  logic [COLI_W-1:0]       in_col;
  logic signed [VAL_W-1:0] in_ov, in_nv;
  logic                    in_rend, in_fin, in_acc;

  assign in_req  = s_axis_tuser[1:0];
  assign in_fin  = s_axis_tuser[2];
  assign in_rend = s_axis_tlast;
  assign in_k    = s_axis_tdata[3:0];
  assign in_col  = s_axis_tdata[11:4];
  assign in_ov   = s_axis_tdata[27:12];
  assign in_nv   = s_axis_tdata[43:28];

  // Configuration
  logic [RNKR_W-1:0] rank_q;
  logic [COLR_W-1:0] cols_q;
  logic [RCW-1:0]    eff_rank;
  logic [CNW-1:0]    eff_cols;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= RNKR_W'(16);
      cols_q <= COLR_W'(256);
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_idx_i))
        CFG_RANK: rank_q <= cfg_data_i[RNKR_W-1:0];
        CFG_COLS: cols_q <= cfg_data_i[COLR_W-1:0];
        default:  rank_q <= rank_q;
      endcase
    end
  end

  assign eff_rank = (32'(rank_q) > MAX_RANK) ? RCW'(MAX_RANK) : RCW'(rank_q);
  assign eff_cols = (32'(cols_q) > MAX_COLUMNS) ? CNW'(MAX_COLUMNS) : CNW'(cols_q);

  // State
  state_e state_q, state_d;
  logic [RANKI_W-1:0]      k_q;
  logic [COLI_W-1:0]       col_q;
  logic signed [VAL_W-1:0] ov_q, nv_q;
  logic                    flush_q, fin_q, upd_q;
  logic [CNW-1:0]          cnt_q;
  logic                    v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [CNW-1:0]          c1_q, c2_q;
  logic signed [PROD_W-1:0] pn_q, po_q;
  logic signed [RD_W-1:0]  s3_q;
  logic signed [RND_W-1:0] r4_q;
  logic [SQ_W-1:0]         sq5_q;
  logic [TOT_W-1:0]        tot_q;
  logic [RCW-1:0]          j_q;
  logic                    dv1_q, dv2_q;
  logic [WSQ_W-1:0]        wsq_q;
  logic [DEN_W-1:0]        den_q;
  logic                    out_v_q;
  logic [RATIO_W-1:0]      ratio_q;
  logic                    zden_q;

  // Control
  logic pass_issue, pass_done, den_issue, den_done, div_start, div_done;
  logic out_load, rload_we, in_upd, in_pass;
  logic [TOT_W-1:0] quo;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_upd   = (32'(in_k) < 32'(eff_rank));
  assign in_pass  = in_upd || in_rend || in_fin;
  assign pass_issue = (state_q == S_PASS) && (cnt_q < CNW'(MAX_COLUMNS));
  assign pass_done  = (cnt_q == CNW'(MAX_COLUMNS)) && !v1_q && !v2_q && !v3_q && !v4_q
                      && !v5_q;
  assign den_issue  = (state_q == S_DEN) && (j_q < eff_rank);
  assign den_done   = (j_q == eff_rank) && !dv1_q && !dv2_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (req_e'(in_req))
            REQ_RIGHT: state_d = S_RLOAD;
            REQ_LEFT:  state_d = in_pass ? S_PASS : S_IDLE;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_RLOAD: state_d = S_IDLE;
      S_PASS:  if (pass_done) state_d = fin_q ? S_DEN : S_IDLE;
      S_DEN:   if (den_done) state_d = S_DIV;
      S_DIV:   if (div_done) state_d = S_OUT;
      S_OUT:   if (!out_v_q || m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == S_IDLE);
    rload_we  = (state_q == S_RLOAD) && (32'(k_q) < MAX_RANK) &&
                (32'(col_q) < MAX_COLUMNS);
    div_start = (state_q == S_DEN) && den_done;
    out_load  = (state_q == S_OUT) && (!out_v_q || m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Latched item
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      k_q     <= in_k;
      col_q   <= in_col;
      ov_q    <= in_ov;
      nv_q    <= in_nv;
      flush_q <= in_rend || in_fin;
      fin_q   <= in_fin;
      upd_q   <= in_upd;
    end
  end

  // Weight store
  logic signed [VAL_W-1:0] wt_old [MAX_RANK];
  logic signed [VAL_W-1:0] wt_new [MAX_RANK];
  logic signed [VAL_W-1:0] wro_q, wrn_q;
  logic [RA-1:0]           wt_raddr;
  logic                    wt_we;

  assign wt_we    = in_acc && (req_e'(in_req) == REQ_WEIGHT) &&
                    (32'(in_k) < MAX_RANK);
  assign wt_raddr = (state_q == S_IDLE) ? RA'(in_k) : RA'(j_q);

  always_ff @(posedge clk_i) begin
    if (wt_we) begin
      wt_old[RA'(in_k)] <= in_ov;
      wt_new[RA'(in_k)] <= in_nv;
    end
    wro_q <= wt_old[wt_raddr];
    wrn_q <= wt_new[wt_raddr];
  end

  // Scaled right factors
  logic [AW-1:0]           f_waddr, f_raddr;
  logic signed [SCL_W-1:0] f_wold, f_wnew, f_rold, f_rnew;

  assign f_waddr = AW'(RA'(k_q)) * AW'(MAX_COLUMNS) + AW'(col_q);
  assign f_raddr = AW'(RA'(k_q)) * AW'(MAX_COLUMNS) + AW'(cnt_q);
  assign f_wold  = ov_q * wro_q;
  assign f_wnew  = nv_q * wrn_q;

  lrrc_fact_mem #(.DEPTH(DEPTH), .AW(AW)) u_fact (
    .clk_i   (clk_i),
    .we_i    (rload_we),
    .waddr_i (f_waddr),
    .wold_i  (f_wold),
    .wnew_i  (f_wnew),
    .raddr_i (f_raddr),
    .rold_o  (f_rold),
    .rnew_o  (f_rnew)
  );

  // Row ring: cell 0 is the column being worked on, new values enter at the tail.
  logic signed [RD_W-1:0] ring [MAX_COLUMNS];
  logic signed [RD_W-1:0] tail_in, head, sat_sum;
  logic signed [PROD_W:0] term;
  logic signed [RD_W+1:0] sum;

  assign head = ring[0];

  always_comb begin
    term = upd_q ? ((PROD_W+1)'(pn_q) - (PROD_W+1)'(po_q)) : '0;
    sum  = (RD_W+2)'(head) + (RD_W+2)'(term);
    if (sum > $signed((RD_W+2)'({1'b0, {(RD_W-1){1'b1}}}))) begin
      sat_sum = {1'b0, {(RD_W-1){1'b1}}};
    end else if (sum < -$signed((RD_W+2)'({1'b1, {(RD_W-1){1'b0}}}))) begin
      sat_sum = {1'b1, {(RD_W-1){1'b0}}};
    end else begin
      sat_sum = sum[RD_W-1:0];
    end
    if (flush_q) begin
      tail_in = '0;
    end else if (c2_q < eff_cols) begin
      tail_in = sat_sum;
    end else begin
      tail_in = head;
    end
  end

  for (genvar i = 0; i < MAX_COLUMNS; i++) begin : g_cell
    logic signed [RD_W-1:0] nxt;
    if (i == MAX_COLUMNS - 1) begin : g_tail
      assign nxt = tail_in;
    end else begin : g_mid
      assign nxt = ring[i+1];
    end
    lrrc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (v2_q),
      .data_i  (nxt),
      .data_o  (ring[i])
    );
  end

  // Pass pipeline: read, multiply, ring update, round, square, accumulate.
  logic signed [RD_W:0]    rbias;
  logic signed [57:0]      sq_full;
  logic [TOT_W:0]          tot_sum;

  assign rbias   = (RD_W+1)'(s3_q) + (RD_W+1)'(524288);
  assign sq_full = r4_q * r4_q;
  assign tot_sum = {1'b0, tot_q} + (TOT_W+1)'(sq5_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      tot_q <= '0;
      j_q   <= '0;
      dv1_q <= 1'b0;
      dv2_q <= 1'b0;
      den_q <= '0;
    end else begin
      if (in_acc) begin
        cnt_q <= '0;
      end else if (pass_issue) begin
        cnt_q <= cnt_q + 1'b1;
      end
      v1_q <= pass_issue;
      v2_q <= v1_q;
      v3_q <= v2_q && flush_q && (c2_q < eff_cols);
      v4_q <= v3_q;
      v5_q <= v4_q;
      if (out_load) begin
        tot_q <= '0;
      end else if (v5_q) begin
        tot_q <= tot_sum[TOT_W] ? {TOT_W{1'b1}} : tot_sum[TOT_W-1:0];
      end
      if (state_q == S_PASS && pass_done) begin
        j_q   <= '0;
        den_q <= '0;
      end else begin
        if (den_issue) begin
          j_q <= j_q + 1'b1;
        end
        if (dv2_q) begin
          den_q <= den_q + DEN_W'(wsq_q);
        end
      end
      dv1_q <= den_issue;
      dv2_q <= dv1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q  <= cnt_q;
    c2_q  <= c1_q;
    pn_q  <= nv_q * f_rnew;
    po_q  <= ov_q * f_rold;
    s3_q  <= sat_sum;
    r4_q  <= rbias[RD_W:20];
    sq5_q <= sq_full[SQ_W-1:0];
    wsq_q <= WSQ_W'(32'(wro_q * wro_q));
  end

  lrrc_div #(.DW(DEN_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (tot_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      zden_q <= (den_q == '0);
      if (den_q == '0) begin
        ratio_q <= '0;
      end else if (|quo[TOT_W-1:RATIO_W]) begin
        ratio_q <= {RATIO_W{1'b1}};
      end else begin
        ratio_q <= quo[RATIO_W-1:0];
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = ratio_q;
  assign m_axis_tuser  = zden_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import lrrc_pkg::*;

  localparam int  NRANK      = 16;
  localparam int  NCOLS      = 256;
  localparam int  ITEM_GOAL  = 1350;
  localparam int  DRAIN_WAIT = 400;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam longint RD_HI   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint RD_LO   = -64'sh0000_8000_0000_0000;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic               zero_den;
  } ratio_t;

  // Tracks the factorization state and queues the ratio each final pair produces.
  class ratio_scoreboard;
    logic signed [15:0] old_w [NRANK];
    logic signed [15:0] new_w [NRANK];
    int                 old_sr [NRANK][NCOLS];
    int                 new_sr [NRANK][NCOLS];
    longint             row_diff [NCOLS];
    logic [63:0]        total_sq;
    logic [4:0]         rank_reg;
    logic [8:0]         cols_reg;
    ratio_t             pending [$];
    int                 errors;

    function new();
      foreach (row_diff[c]) row_diff[c] = 0;
      total_sq = 0;
      rank_reg = 16;
      cols_reg = 256;
      errors   = 0;
    endfunction

    function int eff_rank();
      return (rank_reg > NRANK) ? NRANK : int'(rank_reg);
    endfunction

    function int eff_cols();
      return (cols_reg > NCOLS) ? NCOLS : int'(cols_reg);
    endfunction

    function void set_reg(cfg_e idx, logic [8:0] val);
      if (idx == CFG_RANK) rank_reg = val[4:0];
      else cols_reg = val;
    endfunction

    function void fold_row();
      longint r;
      logic [63:0] sq;
      for (int c = 0; c < eff_cols(); c++) begin
        r  = (row_diff[c] + (64'sd1 <<< 19)) >>> 20;
        sq = 64'(r * r);
        if (total_sq > 64'hFFFF_FFFF_FFFF_FFFF - sq) total_sq = '1;
        else total_sq = total_sq + sq;
      end
      foreach (row_diff[c]) row_diff[c] = 0;
    endfunction

    function void note_transfer(req_e req, int k, int col, logic signed [15:0] ov,
                                logic signed [15:0] nv, bit rend, bit fin);
      longint t, s;
      logic [63:0] den;
      ratio_t res;
      case (req)
        REQ_WEIGHT: begin
          old_w[k] = ov;
          new_w[k] = nv;
        end
        REQ_RIGHT: begin
          old_sr[k][col] = int'(ov) * int'(old_w[k]);
          new_sr[k][col] = int'(nv) * int'(new_w[k]);
        end
        REQ_LEFT: begin
          if (k < eff_rank()) begin
            for (int c = 0; c < eff_cols(); c++) begin
              t = longint'(nv) * longint'(new_sr[k][c]) - longint'(ov) * longint'(old_sr[k][c]);
              s = row_diff[c] + t;
              if (s > RD_HI) s = RD_HI;
              if (s < RD_LO) s = RD_LO;
              row_diff[c] = s;
            end
          end
          if (rend || fin) fold_row();
          if (fin) begin
            den = 0;
            for (int j = 0; j < eff_rank(); j++) den += 64'(longint'(old_w[j]) * old_w[j]);
            if (den == 0) begin
              res.ratio = 0;
              res.zero_den = 1'b1;
            end else begin
              res.ratio = (total_sq / den > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                         : 32'(total_sq / den);
              res.zero_den = 1'b0;
            end
            pending.push_back(res);
            total_sq = 0;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [RATIO_W-1:0] ratio, logic zd);
      ratio_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result ratio=%h zero_denominator=%b", ratio, zd);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (ratio !== exp_r.ratio) begin
        $error("ratio: expected %h, got %h", exp_r.ratio, ratio);
        errors++;
      end
      if (zd !== exp_r.zero_den) begin
        $error("zero_denominator: expected %b, got %b", exp_r.zero_den, zd);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [IN_USER_W-1:0] s_axis_tuser = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [RATIO_W-1:0]   m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_we_i = 1'b0;
  logic                 cfg_idx_i = 1'b0;
  logic [CFGD_W-1:0]    cfg_data_i = '0;

  ratio_scoreboard sb = new();
  bit     right_loaded [NRANK][NCOLS];
  int     item_count = 0;
  bit     calm = 1'b0;
  longint cycles = 0;

  low_rank_relative_change u_top (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: check each transfer, then decide the ready for the next edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
    m_axis_tready <= calm || ($urandom_range(99) >= 17);
  end

  task automatic send(req_e req, int k, int col, logic [15:0] ov, logic [15:0] nv,
                      bit rend, bit fin);
    if (!calm) begin
      while ($urandom_range(99) < 17) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, nv, ov, 8'(col), 4'(k)};
    s_axis_tuser  <= {fin, req};
    s_axis_tlast  <= rend;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_transfer(req, k, col, ov, nv, rend, fin);
    if (req == REQ_RIGHT) right_loaded[k][col] = 1'b1;
    item_count++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_e idx, logic [8:0] val);
    s_axis_tvalid <= 1'b0;
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // Loads every right entry that the current settings will read and is still empty.
  task automatic fill_rights();
    for (int k = 0; k < sb.eff_rank(); k++)
      for (int c = 0; c < sb.eff_cols(); c++)
        if (!right_loaded[k][c]) send(REQ_RIGHT, k, c, pick_value(), pick_value(), 0, 0);
  endtask

  task automatic run_matrix(int rows);
    int n;
    bit fin;
    for (int r = 0; r < rows; r++) begin
      n = $urandom_range(1, sb.eff_rank() + 2);
      for (int i = 0; i < n; i++) begin
        fin = (r == rows - 1) && (i == n - 1);
        case ($urandom_range(9))
          0: send(REQ_NONE, $urandom_range(15), $urandom_range(255), 16'($urandom()),
                  16'($urandom()), $urandom_range(1), $urandom_range(1));
          1: send(REQ_RIGHT, $urandom_range(15), $urandom_range(255), pick_value(),
                  pick_value(), $urandom_range(1), $urandom_range(1));
          default: ;
        endcase
        send(REQ_LEFT, ($urandom_range(4) == 0) ? $urandom_range(15)
                                                : $urandom_range(sb.eff_rank() - 1),
             $urandom_range(255), pick_value(), pick_value(),
             (i == n - 1) ? !(fin && $urandom_range(1)) : 1'b0, fin);
      end
    end
  endtask

  initial begin
    logic [8:0] rank_val, cols_val;
    int phase;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: every weight, extremes, marks on other requests, a late weight.
    send(REQ_WEIGHT, 0, 0, 16'h8000, 16'h7FFF, 1, 1);
    send(REQ_WEIGHT, 1, 255, 16'h7FFF, 16'h8000, 0, 0);
    for (int k = 2; k < NRANK; k++) send(REQ_WEIGHT, k, 0, pick_value(), pick_value(), 0, 0);
    send(REQ_NONE, 15, 255, 16'hFFFF, 16'hFFFF, 1, 1);
    write_reg(CFG_RANK, 2);
    write_reg(CFG_COLS, 3);
    send(REQ_RIGHT, 0, 0, 16'h8000, 16'h8000, 1, 1);
    send(REQ_RIGHT, 0, 1, 16'h7FFF, 16'h7FFF, 0, 0);
    send(REQ_RIGHT, 0, 2, 16'h0001, 16'hFFFF, 0, 0);
    fill_rights();
    send(REQ_WEIGHT, 1, 0, 16'h0100, 16'h0200, 0, 0);
    send(REQ_LEFT, 0, 0, 16'h8000, 16'h7FFF, 1, 0);
    send(REQ_LEFT, 1, 0, 16'h7FFF, 16'h8000, 0, 0);
    send(REQ_LEFT, 9, 0, 16'h1234, 16'h4321, 1, 0);
    send(REQ_LEFT, 0, 0, 16'h0000, 16'h7FFF, 0, 1);
    settle();
    // Zero denominator.
    send(REQ_WEIGHT, 0, 0, 16'h0000, 16'h0100, 0, 0);
    write_reg(CFG_RANK, 1);
    send(REQ_LEFT, 0, 0, 16'h4000, 16'h4000, 1, 1);
    settle();
    send(REQ_WEIGHT, 0, 0, 16'h0001, 16'h7FFF, 0, 0);

    phase = 0;
    while (item_count < ITEM_GOAL) begin
      case (phase)
        0: begin rank_val = 1;  cols_val = 256; end
        1: begin rank_val = 2;  cols_val = 511; end
        2: begin rank_val = 31; cols_val = 1;   end
        3: begin rank_val = 0;  cols_val = 4;   end
        4: begin rank_val = 16; cols_val = 0;   end
        default: begin
          rank_val = ($urandom_range(3) == 0) ? 16 : $urandom_range(1, 16);
          cols_val = $urandom_range(1, 8);
        end
      endcase
      calm = (phase >= 8 && phase < 14);
      write_reg(CFG_RANK, rank_val);
      write_reg(CFG_COLS, cols_val);
      if ($urandom_range(3) == 0)
        send(REQ_WEIGHT, $urandom_range(15), $urandom_range(255), pick_value(),
             pick_value(), 0, 0);
      fill_rights();
      if (sb.eff_rank() == 0) begin
        send(REQ_LEFT, $urandom_range(15), 0, pick_value(), pick_value(), 1, 0);
        send(REQ_LEFT, $urandom_range(15), 0, pick_value(), pick_value(), 0, 1);
      end else begin
        run_matrix((sb.eff_cols() > 8) ? 1 : $urandom_range(1, 4));
      end
      settle();
      phase++;
    end

    calm = 1'b0;
    settle();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
